// ===== rtl/core/frame_element_stiffness_matrix_macros.svh =====
// Assertion macros for the frame element stiffness matrix block.
// Taken in by the checker module; needs nothing else.
`ifndef FRAME_ELEMENT_STIFFNESS_MATRIX_MACROS_SVH
`define FRAME_ELEMENT_STIFFNESS_MATRIX_MACROS_SVH

// Property checked outside reset.
`define FESM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define FESM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fesm_pkg.sv =====
// Shared types, widths, codes and the saturating negation helper of the frame element
// stiffness matrix block. Depends on nothing.
package fesm_pkg;

  localparam int MATRIX_ORDER   = 6;
  localparam int NODE_DOF_COUNT = 3;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int LEN2_W    = 66;
  localparam int LEN_W     = 34;
  localparam int L3_W      = 100;
  localparam int RIG_W     = 48;
  localparam int VAL_W     = 64;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int DIVN_W    = 128;
  localparam int DIVD_W    = 100;
  localparam int DIVQ_W    = 63;
  localparam int MUL_W     = 68;
  localparam int PROD_W    = 128;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIAL   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BENDING = 4'd1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last_entry;
    logic                    degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     degen;
  } work_t;

  // Element terms handed from the compute sequencer to the emitter.
  typedef struct packed {
    logic signed [VAL_W-1:0] tr_a;
    logic signed [VAL_W-1:0] tr_b;
    logic signed [VAL_W-1:0] tr_c;
    logic signed [VAL_W-1:0] cpl0;
    logic signed [VAL_W-1:0] cpl1;
    logic [DIVQ_W-1:0]       k4;
    logic [DIVQ_W-1:0]       k2;
    logic                    degen;
  } terms_t;

  function automatic logic signed [VAL_W-1:0] sat_neg(input logic signed [VAL_W-1:0] x);
    if (x == VAL_MIN) begin
      return VAL_MAX;
    end
    return -x;
  endfunction

endpackage

// ===== rtl/core/fesm_queue.sv =====
// Small register queue with push/full and pop/empty sides.
// Generic; depends on nothing.
module fesm_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/fesm_front.sv =====
// Front end: takes element end points, forms the coordinate differences and
// flags zero-length elements. Depends on fesm_pkg and fesm_queue.
module fesm_front #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fesm_pkg::in_item_t in_data,
  input  logic               q_pop,
  output logic               q_empty,
  output fesm_pkg::work_t    q_data
);

  fesm_pkg::work_t item;
  logic [$bits(fesm_pkg::work_t)-1:0] q_rdata;

  always_comb begin
    item.dx = $signed({in_data.end_x[fesm_pkg::COORD_W-1], in_data.end_x})
            - $signed({in_data.start_x[fesm_pkg::COORD_W-1], in_data.start_x});
    item.dy = $signed({in_data.end_y[fesm_pkg::COORD_W-1], in_data.end_y})
            - $signed({in_data.start_y[fesm_pkg::COORD_W-1], in_data.start_y});
    item.degen = (item.dx == '0) && (item.dy == '0);
  end

  fesm_queue #(
    .W     ($bits(fesm_pkg::work_t)),
    .DEPTH (DEPTH)
  ) u_work_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (item),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  assign q_data = fesm_pkg::work_t'(q_rdata);

endmodule

// ===== rtl/core/fesm_div.sv =====
// Restoring divider, one quotient bit a cycle, with the quotient capped at
// 2^63-1. Depends on fesm_pkg.
module fesm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fesm_pkg::DIVN_W-1:0]   num,
  input  logic [fesm_pkg::DIVD_W-1:0]   den,
  output logic                          done,
  output logic [fesm_pkg::DIVQ_W-1:0]   quo
);

  localparam int QW = fesm_pkg::DIVQ_W;
  localparam int DW = fesm_pkg::DIVD_W;
  localparam int NW = fesm_pkg::DIVN_W;

  logic          busy_r;
  logic          done_r;
  logic [5:0]    cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] num_r;
  logic [QW-1:0] quo_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, num_r[QW-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      // A quotient of 2^63 or more is caught up front and saturates.
      if (DW'(num[NW-1:QW]) >= den) begin
        quo_r <= '1;
      end else begin
        rem_r <= DW'(num[NW-1:QW]);
        num_r <= num[QW-1:0];
        quo_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      num_r <= {num_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (DW'(num[NW-1:QW]) >= den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 6'(QW);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/fesm_mul.sv =====
// Unsigned 68 x 68 multiplier built from four 34 x 34 partial products,
// one a cycle, accumulated into a wide sum. Depends on fesm_pkg.
module fesm_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fesm_pkg::MUL_W-1:0]   a,
  input  logic [fesm_pkg::MUL_W-1:0]   b,
  output logic                         done,
  output logic [fesm_pkg::PROD_W-1:0]  prod
);

  localparam int MW = fesm_pkg::MUL_W;
  localparam int HW = MW / 2;
  localparam int AW = 2 * MW;

  logic          busy_r;
  logic          done_r;
  logic [2:0]    step_r;
  logic [1:0]    pstep_r;
  logic [MW-1:0] a_r;
  logic [MW-1:0] b_r;
  logic [MW-1:0] pp_r;
  logic [AW-1:0] acc_r;
  logic [HW-1:0] a_sel;
  logic [HW-1:0] b_sel;
  logic [AW-1:0] pp_shifted;

  assign a_sel = step_r[1] ? a_r[MW-1:HW] : a_r[HW-1:0];
  assign b_sel = step_r[0] ? b_r[MW-1:HW] : b_r[HW-1:0];

  always_comb begin
    case (pstep_r)
      2'd0:    pp_shifted = AW'(pp_r);
      2'd1:    pp_shifted = AW'(pp_r) << HW;
      2'd2:    pp_shifted = AW'(pp_r) << HW;
      default: pp_shifted = AW'(pp_r) << MW;
    endcase
  end

  assign done = done_r;
  assign prod = acc_r[fesm_pkg::PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        pp_r    <= a_sel * b_sel;
        pstep_r <= step_r[1:0];
      end
      if (step_r != 3'd0) begin
        acc_r <= acc_r + pp_shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/fesm_back.sv =====
// Compute sequencer: length by digit-serial square root, then a fixed
// programme of divisions and products on the shared units, giving the
// element terms. Depends on fesm_pkg, fesm_div and fesm_mul.
module fesm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fesm_pkg::RIG_W-1:0]    axial_rigidity,
  input  logic [fesm_pkg::RIG_W-1:0]    bending_rigidity,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  fesm_pkg::work_t               q_data,
  output logic                          terms_valid,
  input  logic                          terms_ready,
  output fesm_pkg::terms_t              terms
);

  localparam int DW  = fesm_pkg::DIFF_W;
  localparam int VW  = fesm_pkg::VAL_W;
  localparam int QW  = fesm_pkg::DIVQ_W;
  localparam int NW  = fesm_pkg::DIVN_W;
  localparam int DDW = fesm_pkg::DIVD_W;
  localparam int MW  = fesm_pkg::MUL_W;
  localparam int PW  = fesm_pkg::PROD_W;
  localparam int L2W = fesm_pkg::LEN2_W;
  localparam int LW  = fesm_pkg::LEN_W;
  localparam int L3W = fesm_pkg::L3_W;
  localparam int RW  = fesm_pkg::RIG_W;
  localparam int RTW = 35;
  localparam int REMW = RTW + 2;
  localparam int SVW = 2 * RTW;
  localparam int UW  = 31;
  localparam int FW  = 61;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [4:0] PC_SQX  = 5'd0;
  localparam logic [4:0] PC_LEN2 = 5'd1;
  localparam logic [4:0] PC_SQRT = 5'd2;
  localparam logic [4:0] PC_L3   = 5'd3;
  localparam logic [4:0] PC_DC   = 5'd4;
  localparam logic [4:0] PC_DS   = 5'd5;
  localparam logic [4:0] PC_DA   = 5'd6;
  localparam logic [4:0] PC_DK4  = 5'd7;
  localparam logic [4:0] PC_DK2  = 5'd8;
  localparam logic [4:0] PC_DM   = 5'd9;
  localparam logic [4:0] PC_DB   = 5'd10;
  localparam logic [4:0] PC_CC   = 5'd11;
  localparam logic [4:0] PC_SS   = 5'd12;
  localparam logic [4:0] PC_CS   = 5'd13;
  localparam logic [4:0] PC_ACC  = 5'd14;
  localparam logic [4:0] PC_BSS  = 5'd15;
  localparam logic [4:0] PC_ACS  = 5'd16;
  localparam logic [4:0] PC_BCS  = 5'd17;
  localparam logic [4:0] PC_ASS  = 5'd18;
  localparam logic [4:0] PC_BCC  = 5'd19;
  localparam logic [4:0] PC_MS   = 5'd20;
  localparam logic [4:0] PC_MC   = 5'd21;
  localparam logic [4:0] PC_COMB = 5'd22;

  logic [2:0]      state_r, state_nxt;
  logic [4:0]      pc_r, pc_nxt;
  logic [DW-1:0]   ux_r, uy_r;
  logic            cneg_r, sneg_r;
  logic [DW+31:0]  sqx_r;
  logic [L2W-1:0]  len2_r;
  logic [LW-1:0]   len_r;
  logic [L3W-1:0]  l3_r;
  logic [UW-1:0]   cmag_r, smag_r;
  logic [QW-1:0]   a_r, k4_r, k2_r, m_r, b_r;
  logic [FW-1:0]   cc_r, ss_r, cs_r;
  logic signed [VW-1:0] acc_r, bss_r, acs_r, bcs_r, ass_r, bcc_r, ms_r, mc_r;
  fesm_pkg::terms_t terms_r;

  logic [SVW-1:0]  sq_v_r;
  logic [REMW-1:0] sq_rem_r;
  logic [RTW-1:0]  sq_root_r;
  logic [5:0]      sq_cnt_r;
  logic [REMW+1:0] sq_remx;
  logic [REMW+1:0] sq_trial;
  logic            sq_fits;

  logic            is_div;
  logic            div_start, div_done;
  logic            mul_start, mul_done;
  logic            unit_done;
  logic [NW-1:0]   div_num;
  logic [DDW-1:0]  div_den;
  logic [QW-1:0]   div_quo;
  logic [MW-1:0]   mul_a, mul_b;
  logic [PW-1:0]   mul_prod;
  logic            sc_sh30, sc_neg;
  logic signed [VW-1:0] sc_val;
  logic [RW+2:0]   ei6;
  logic [RW+3:0]   ei12;

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] x,
                                                    input logic signed [VW-1:0] y);
    logic signed [VW:0] sum;
    sum = {x[VW-1], x} + {y[VW-1], y};
    if (sum[VW] != sum[VW-1]) begin
      return sum[VW] ? fesm_pkg::VAL_MIN : fesm_pkg::VAL_MAX;
    end
    return sum[VW-1:0];
  endfunction

  // Round half up at the binary point, then saturate with the sign applied.
  function automatic logic signed [VW-1:0] scale_fn(input logic [PW-1:0] prod,
                                                     input logic sh30, input logic neg);
    logic [PW-1:0] p;
    p = sh30 ? ((prod + (PW'(1) << 29)) >> 30) : ((prod + (PW'(1) << 59)) >> 60);
    if (neg) begin
      if (p[PW-1:VW-1] != '0) begin
        return fesm_pkg::VAL_MIN;
      end
      return -$signed({1'b0, p[VW-2:0]});
    end
    if (p[PW-1:VW-1] != '0) begin
      return fesm_pkg::VAL_MAX;
    end
    return $signed({1'b0, p[VW-2:0]});
  endfunction

  assign is_div    = (pc_r >= PC_DC) && (pc_r <= PC_DB);
  assign div_start = (state_r == ST_ISSUE) && is_div;
  assign mul_start = (state_r == ST_ISSUE) && !is_div && (pc_r != PC_SQRT)
                     && (pc_r != PC_COMB);
  assign unit_done = is_div ? div_done : mul_done;

  assign ei6  = ({3'b0, bending_rigidity} << 2) + ({3'b0, bending_rigidity} << 1);
  assign ei12 = {ei6, 1'b0};

  always_comb begin
    case (pc_r)
      PC_DC: begin
        div_num = (NW'(ux_r) << 30) + NW'(len_r >> 1);
        div_den = DDW'(len_r);
      end
      PC_DS: begin
        div_num = (NW'(uy_r) << 30) + NW'(len_r >> 1);
        div_den = DDW'(len_r);
      end
      PC_DA: begin
        div_num = (NW'(axial_rigidity) << 24) + NW'(len_r >> 1);
        div_den = DDW'(len_r);
      end
      PC_DK4: begin
        div_num = (NW'(bending_rigidity) << 26) + NW'(len_r >> 1);
        div_den = DDW'(len_r);
      end
      PC_DK2: begin
        div_num = (NW'(bending_rigidity) << 25) + NW'(len_r >> 1);
        div_den = DDW'(len_r);
      end
      PC_DM: begin
        div_num = (NW'(ei6) << 40) + NW'(len2_r >> 1);
        div_den = DDW'(len2_r);
      end
      default: begin
        div_num = (NW'(ei12) << 56) + NW'(l3_r >> 1);
        div_den = DDW'(l3_r);
      end
    endcase
  end

  always_comb begin
    sc_sh30 = (pc_r == PC_MS) || (pc_r == PC_MC);
    case (pc_r)
      PC_SQX:  begin mul_a = MW'(ux_r);   mul_b = MW'(ux_r);   sc_neg = 1'b0; end
      PC_LEN2: begin mul_a = MW'(uy_r);   mul_b = MW'(uy_r);   sc_neg = 1'b0; end
      PC_L3:   begin mul_a = MW'(len2_r); mul_b = MW'(len_r);  sc_neg = 1'b0; end
      PC_CC:   begin mul_a = MW'(cmag_r); mul_b = MW'(cmag_r); sc_neg = 1'b0; end
      PC_SS:   begin mul_a = MW'(smag_r); mul_b = MW'(smag_r); sc_neg = 1'b0; end
      PC_CS:   begin mul_a = MW'(cmag_r); mul_b = MW'(smag_r); sc_neg = 1'b0; end
      PC_ACC:  begin mul_a = MW'(a_r);    mul_b = MW'(cc_r);   sc_neg = 1'b0; end
      PC_BSS:  begin mul_a = MW'(b_r);    mul_b = MW'(ss_r);   sc_neg = 1'b0; end
      PC_ACS:  begin mul_a = MW'(a_r);    mul_b = MW'(cs_r);   sc_neg = cneg_r ^ sneg_r; end
      PC_BCS:  begin mul_a = MW'(b_r);    mul_b = MW'(cs_r);   sc_neg = cneg_r ^ sneg_r; end
      PC_ASS:  begin mul_a = MW'(a_r);    mul_b = MW'(ss_r);   sc_neg = 1'b0; end
      PC_BCC:  begin mul_a = MW'(b_r);    mul_b = MW'(cc_r);   sc_neg = 1'b0; end
      PC_MS:   begin mul_a = MW'(m_r);    mul_b = MW'(smag_r); sc_neg = sneg_r; end
      PC_MC:   begin mul_a = MW'(m_r);    mul_b = MW'(cmag_r); sc_neg = cneg_r; end
      default: begin mul_a = '0;          mul_b = '0;          sc_neg = 1'b0; end
    endcase
  end

  assign sc_val = scale_fn(mul_prod, sc_sh30, sc_neg);

  // One root bit per cycle from the next pair of radicand bits.
  assign sq_remx  = {sq_rem_r, sq_v_r[SVW-1:SVW-2]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_fits  = (sq_remx >= sq_trial);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          pc_nxt    = PC_SQX;
          state_nxt = q_data.degen ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (pc_r == PC_SQRT) begin
          state_nxt = ST_SQRT;
        end else if (pc_r == PC_COMB) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_SQRT: begin
        if (sq_cnt_r == '0) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (terms_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= PC_SQX;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ux_r   <= q_data.dx[DW-1] ? DW'(-q_data.dx) : DW'(q_data.dx);
        uy_r   <= q_data.dy[DW-1] ? DW'(-q_data.dy) : DW'(q_data.dy);
        cneg_r <= q_data.dx[DW-1];
        sneg_r <= q_data.dy[DW-1];
        terms_r       <= '0;
        terms_r.degen <= q_data.degen;
      end
      ST_ISSUE: begin
        if (pc_r == PC_SQRT) begin
          sq_v_r    <= SVW'(len2_r);
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          sq_cnt_r  <= 6'(RTW);
        end
        if (pc_r == PC_COMB) begin
          terms_r.tr_a  <= sat_add(acc_r, bss_r);
          terms_r.tr_b  <= sat_add(acs_r, fesm_pkg::sat_neg(bcs_r));
          terms_r.tr_c  <= sat_add(ass_r, bcc_r);
          terms_r.cpl0  <= fesm_pkg::sat_neg(ms_r);
          terms_r.cpl1  <= mc_r;
          terms_r.k4    <= k4_r;
          terms_r.k2    <= k2_r;
          terms_r.degen <= 1'b0;
        end
      end
      ST_SQRT: begin
        if (sq_cnt_r != '0) begin
          sq_rem_r  <= sq_fits ? REMW'(sq_remx - sq_trial) : sq_remx[REMW-1:0];
          sq_root_r <= {sq_root_r[RTW-2:0], sq_fits};
          sq_v_r    <= sq_v_r << 2;
          sq_cnt_r  <= sq_cnt_r - 1'b1;
        end else begin
          // Round to nearest: step up when the remainder exceeds the root.
          len_r <= (sq_rem_r > REMW'(sq_root_r)) ? LW'(sq_root_r + 1'b1) : LW'(sq_root_r);
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          case (pc_r)
            PC_SQX:  sqx_r  <= mul_prod[DW+31:0];
            PC_LEN2: len2_r <= L2W'(sqx_r) + mul_prod[L2W-1:0];
            PC_L3:   l3_r   <= mul_prod[L3W-1:0];
            PC_DC:   cmag_r <= div_quo[UW-1:0];
            PC_DS:   smag_r <= div_quo[UW-1:0];
            PC_DA:   a_r    <= div_quo;
            PC_DK4:  k4_r   <= div_quo;
            PC_DK2:  k2_r   <= div_quo;
            PC_DM:   m_r    <= div_quo;
            PC_DB:   b_r    <= div_quo;
            PC_CC:   cc_r   <= mul_prod[FW-1:0];
            PC_SS:   ss_r   <= mul_prod[FW-1:0];
            PC_CS:   cs_r   <= mul_prod[FW-1:0];
            PC_ACC:  acc_r  <= sc_val;
            PC_BSS:  bss_r  <= sc_val;
            PC_ACS:  acs_r  <= sc_val;
            PC_BCS:  bcs_r  <= sc_val;
            PC_ASS:  ass_r  <= sc_val;
            PC_BCC:  bcc_r  <= sc_val;
            PC_MS:   ms_r   <= sc_val;
            PC_MC:   mc_r   <= sc_val;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  fesm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  fesm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign terms_valid = (state_r == ST_DONE);
  assign terms       = terms_r;

endmodule

// ===== rtl/core/fesm_emit.sv =====
// Emitter: walks the 36 entries of one element row-major, picks each value
// from the held terms and feeds the result queue. Depends on fesm_pkg and
// fesm_queue.
module fesm_emit #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                terms_valid,
  output logic                terms_ready,
  input  fesm_pkg::terms_t    terms,
  output logic                out_empty,
  input  logic                out_pop,
  output fesm_pkg::out_item_t out_data
);

  localparam int IW = fesm_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(fesm_pkg::MATRIX_ORDER - 1);
  localparam logic [IW-1:0] NODE_DOF = IW'(fesm_pkg::NODE_DOF_COUNT);
  localparam logic [IW-1:0] ROT_DOF  = IW'(fesm_pkg::NODE_DOF_COUNT - 1);

  logic                busy_r;
  logic [IW-1:0]       row_r;
  logic [IW-1:0]       col_r;
  fesm_pkg::terms_t    terms_r;
  fesm_pkg::out_item_t item;
  logic                oq_full;
  logic                do_push;
  logic [$bits(fesm_pkg::out_item_t)-1:0] oq_rdata;

  function automatic logic signed [fesm_pkg::VAL_W-1:0] entry_fn(
      input logic [IW-1:0] row, input logic [IW-1:0] col, input fesm_pkg::terms_t t);
    logic p;
    logic q;
    logic [IW-1:0] i;
    logic [IW-1:0] j;
    logic signed [fesm_pkg::VAL_W-1:0] v;
    p = (row >= NODE_DOF);
    q = (col >= NODE_DOF);
    i = p ? row - NODE_DOF : row;
    j = q ? col - NODE_DOF : col;
    if (t.degen) begin
      return '0;
    end
    if ((i != ROT_DOF) && (j != ROT_DOF)) begin
      // Translational block, negated off the node diagonal.
      v = (i != j) ? t.tr_b : ((i == '0) ? t.tr_a : t.tr_c);
      return (p == q) ? v : fesm_pkg::sat_neg(v);
    end
    if (i != ROT_DOF) begin
      v = (i == '0) ? t.cpl0 : t.cpl1;
      return p ? fesm_pkg::sat_neg(v) : v;
    end
    if (j != ROT_DOF) begin
      v = (j == '0) ? t.cpl0 : t.cpl1;
      return q ? fesm_pkg::sat_neg(v) : v;
    end
    return (p == q) ? $signed({1'b0, t.k4}) : $signed({1'b0, t.k2});
  endfunction

  assign terms_ready = !busy_r;
  assign do_push     = busy_r && !oq_full;

  always_comb begin
    item.row_index   = row_r;
    item.col_index   = col_r;
    item.entry_value = entry_fn(row_r, col_r, terms_r);
    item.last_entry  = (row_r == LAST_IDX) && (col_r == LAST_IDX);
    item.degenerate  = terms_r.degen;
  end

  always_ff @(posedge clk) begin
    if (!busy_r && terms_valid) begin
      terms_r <= terms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (!busy_r) begin
      if (terms_valid) begin
        busy_r <= 1'b1;
        row_r  <= '0;
        col_r  <= '0;
      end
    end else if (do_push) begin
      if (col_r == LAST_IDX) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
        if (row_r == LAST_IDX) begin
          busy_r <= 1'b0;
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  fesm_queue #(
    .W     ($bits(fesm_pkg::out_item_t)),
    .DEPTH (DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (do_push),
    .full  (oq_full),
    .wdata (item),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (oq_rdata)
  );

  assign out_data = fesm_pkg::out_item_t'(oq_rdata);

endmodule

// ===== rtl/core/frame_element_stiffness_matrix.sv =====
// Top level of the 2D frame element stiffness matrix block: configuration
// registers, front end, compute sequencer and emitter. Depends on fesm_pkg,
// fesm_front, fesm_back and fesm_emit.
//
//   Channel  Handshake          Payload
//   in_      in_push / in_full  in_data   : end points, Q16.16
//   out_     out_pop / out_empty out_data : row, column, Q40.24 entry, flags
//   cfg_     cfg_valid/cfg_ready cfg_index, cfg_data : EA, EI, Q32.16
//
// In the compute sequencer an element of non-zero length spends most of its
// time in seven 63-step divisions on the shared divider (a division whose
// quotient saturates skips the steps); a zero-length element skips the
// divisions and products and hands all-zero terms straight to the emitter,
// which still puts all 36 of its entries on the result port.
// Elements queue up in front while one is being computed, and the next is
// computed while the previous matrix drains, so the result side may stall
// freely. Reset is synchronous and clears the queues, sequencer and both
// rigidities; no clearing pass is needed.
module frame_element_stiffness_matrix #(
  parameter int WORK_DEPTH   = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  fesm_pkg::in_item_t                in_data,
  output logic                              out_empty,
  input  logic                              out_pop,
  output fesm_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fesm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fesm_pkg::RIG_W-1:0]        cfg_data
);

  logic [fesm_pkg::RIG_W-1:0] axial_r;
  logic [fesm_pkg::RIG_W-1:0] bending_r;
  logic                       q_empty;
  logic                       q_pop;
  fesm_pkg::work_t            q_data;
  logic                       terms_valid;
  logic                       terms_ready;
  fesm_pkg::terms_t           terms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axial_r   <= '0;
      bending_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fesm_pkg::CFG_AXIAL:   axial_r   <= cfg_data;
        fesm_pkg::CFG_BENDING: bending_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fesm_front #(
    .DEPTH (WORK_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_data  (q_data)
  );

  fesm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .axial_rigidity   (axial_r),
    .bending_rigidity (bending_r),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_data           (q_data),
    .terms_valid      (terms_valid),
    .terms_ready      (terms_ready),
    .terms            (terms)
  );

  fesm_emit #(
    .DEPTH (RESULT_DEPTH)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/core/fesm_checker.sv =====
// Port-level checks of the frame element stiffness matrix block, bound to
// the top level. Depends on fesm_pkg and the assertion macro header.
`include "frame_element_stiffness_matrix_macros.svh"

module fesm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input fesm_pkg::out_item_t out_data
);

  // The last flag marks exactly the bottom-right entry.
  `FESM_ASSERT(a_last_pos, clk, rst_n, !out_empty |-> (out_data.last_entry == ((out_data.row_index == 3'd5) && (out_data.col_index == 3'd5))), "last_entry not on the final entry")

  // Indices stay inside the matrix.
  `FESM_ASSERT(a_idx_range, clk, rst_n, !out_empty |-> ((out_data.row_index < 3'd6) && (out_data.col_index < 3'd6)), "entry index out of range")

  // A zero-length element yields only zero entries.
  `FESM_ASSERT(a_degen_zero, clk, rst_n, (!out_empty && out_data.degenerate) |-> (out_data.entry_value == '0), "degenerate element with non-zero entry")

  // A waiting result holds until it is taken.
  `FESM_ASSERT(a_out_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "waiting result changed")

  // The result queue comes out of reset empty and the input queue not full.
  `FESM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (out_empty && !in_full), "queues not empty after reset")

endmodule

bind frame_element_stiffness_matrix fesm_checker u_fesm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== verif/tb.sv =====
// Self-checking testbench for frame_element_stiffness_matrix: it drives element end
// points and rigidities, and predicts every matrix entry in bit-exact fixed point.
// Depends on fesm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

  localparam int  RESET_CYCLES = 7;
  localparam int  CYCLE_LIMIT  = 2_000_000;
  localparam int  SETTLE       = 64;
  localparam int  ORDER        = fesm_pkg::MATRIX_ORDER;
  localparam int  NDOF         = fesm_pkg::NODE_DOF_COUNT;
  localparam int  ENTRIES      = ORDER * ORDER;
  localparam logic [fesm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LOW  = 4'd2;
  localparam logic [fesm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HIGH = 4'd15;
  localparam logic [fesm_pkg::RIG_W-1:0]     RIG_MAX        = '1;
  localparam logic [255:0]                   CAP63          = 256'h7FFF_FFFF_FFFF_FFFF;

  logic                           clk;
  logic                           rst_n;
  logic                           in_push;
  logic                           in_full;
  fesm_pkg::in_item_t             in_data;
  logic                           out_empty;
  logic                           out_pop;
  fesm_pkg::out_item_t            out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [fesm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fesm_pkg::RIG_W-1:0]     cfg_data;

  // Rigidities as the block should currently hold them.
  logic [fesm_pkg::RIG_W-1:0] ea_now;
  logic [fesm_pkg::RIG_W-1:0] ei_now;

  fesm_pkg::out_item_t entries_due[$];
  int        fail_count;
  int        cycle_count;
  int        hold_cycles;
  bit        eager_send;
  bit        eager_pop;

  frame_element_stiffness_matrix i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point stiffness arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint negate_clamped(longint x);
    if (x == fesm_pkg::VAL_MIN) begin
      return fesm_pkg::VAL_MAX;
    end
    return -x;
  endfunction

  function automatic longint add_clamped(longint x, longint y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      return fesm_pkg::VAL_MAX;
    end
    if (s < -65'sh0_8000_0000_0000_0000) begin
      return fesm_pkg::VAL_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] div_round_cap(logic [255:0] n, logic [255:0] d);
    logic [255:0] q;
    q = (n + (d >> 1)) / d;
    return (q > CAP63) ? CAP63[63:0] : q[63:0];
  endfunction

  // Base term times a signed fraction, rounded with halves away from zero.
  function automatic longint scale_term(logic [63:0] base, longint f, int sh);
    logic [255:0] mag;
    logic [255:0] p;
    mag = (f < 0) ? 256'(-f) : 256'(f);
    p = ((256'(base) * mag) + (256'd1 << (sh - 1))) >> sh;
    if (f < 0) begin
      return (p >= (256'd1 << 63)) ? fesm_pkg::VAL_MIN : -longint'(p[63:0]);
    end
    return (p > CAP63) ? fesm_pkg::VAL_MAX : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] root_nearest(logic [255:0] v);
    logic [255:0] r;
    logic [255:0] t;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (256'd1 << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    if (v - r * r > r) begin
      r = r + 1;
    end
    return r[63:0];
  endfunction

  function automatic longint direction_ratio(longint d, logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 30) + (len >> 1)) / len;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Appends the 36 entries that one element must produce.
  function automatic void predict_matrix(fesm_pkg::in_item_t el);
    longint              mat[ORDER][ORDER];
    longint              dx, dy, c, s, cc, ss, cs;
    logic [255:0]        ux, uy, len2;
    logic [63:0]         len, a, k4, k2, m, b;
    longint              tr[2][2];
    longint              cpl[2];
    bit                  degen;
    fesm_pkg::out_item_t e;
    dx = longint'(el.end_x) - longint'(el.start_x);
    dy = longint'(el.end_y) - longint'(el.start_y);
    ux = (dx < 0) ? 256'(-dx) : 256'(dx);
    uy = (dy < 0) ? 256'(-dy) : 256'(dy);
    len2 = ux * ux + uy * uy;
    degen = (len2 == 0);
    foreach (mat[i, j]) mat[i][j] = 0;
    if (!degen) begin
      len = root_nearest(len2);
      c = direction_ratio(dx, len);
      s = direction_ratio(dy, len);
      cc = c * c;
      ss = s * s;
      cs = c * s;
      a  = div_round_cap(256'(ea_now) << 24, 256'(len));
      k4 = div_round_cap(256'(ei_now) << 26, 256'(len));
      k2 = div_round_cap(256'(ei_now) << 25, 256'(len));
      m  = div_round_cap((256'(ei_now) * 6) << 40, len2);
      b  = div_round_cap((256'(ei_now) * 12) << 56, len2 * 256'(len));
      tr[0][0] = add_clamped(scale_term(a, cc, 60), scale_term(b, ss, 60));
      tr[0][1] = add_clamped(scale_term(a, cs, 60), negate_clamped(scale_term(b, cs, 60)));
      tr[1][0] = tr[0][1];
      tr[1][1] = add_clamped(scale_term(a, ss, 60), scale_term(b, cc, 60));
      cpl[0] = negate_clamped(scale_term(m, s, 30));
      cpl[1] = scale_term(m, c, 30);
      for (int p = 0; p < 2; p++) begin
        for (int q = 0; q < 2; q++) begin
          for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
              mat[p*NDOF+i][q*NDOF+j] =
                (p == q) ? tr[i][j] : negate_clamped(tr[i][j]);
            end
            mat[p*NDOF+i][q*NDOF+2] =
              (p == 0) ? cpl[i] : negate_clamped(cpl[i]);
            mat[p*NDOF+2][q*NDOF+i] =
              (q == 0) ? cpl[i] : negate_clamped(cpl[i]);
          end
          mat[p*NDOF+2][q*NDOF+2] = (p == q) ? k4 : k2;
        end
      end
    end
    for (int k = 0; k < ENTRIES; k++) begin
      e.row_index   = fesm_pkg::IDX_W'(k / ORDER);
      e.col_index   = fesm_pkg::IDX_W'(k % ORDER);
      e.entry_value = mat[k / ORDER][k % ORDER];
      e.last_entry  = (k == ENTRIES - 1);
      e.degenerate  = degen;
      entries_due.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one element; returns after the rising edge that accepts it.
  task automatic send_element(fesm_pkg::in_item_t el);
    int gap;
    @(negedge clk);
    gap = eager_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = el;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    predict_matrix(el);
  endtask

  task automatic send_points(int sx, int sy, int ex, int ey);
    fesm_pkg::in_item_t el;
    el.start_x = sx;
    el.start_y = sy;
    el.end_x   = ex;
    el.end_y   = ey;
    send_element(el);
  endtask

  // Waits until every expected entry has arrived and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    wait (entries_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rigidity(logic [fesm_pkg::CFG_IDX_W-1:0] idx,
                                logic [fesm_pkg::RIG_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fesm_pkg::CFG_AXIAL) begin
      ea_now = value;
    end else if (idx == fesm_pkg::CFG_BENDING) begin
      ei_now = value;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [fesm_pkg::RIG_W-1:0] rand_rigidity();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return RIG_MAX;
      2: return fesm_pkg::RIG_W'({$urandom, $urandom});
      3: return fesm_pkg::RIG_W'($urandom_range(1, 1 << 20));
      default: return fesm_pkg::RIG_W'({$urandom, $urandom} >> $urandom_range(16, 60));
    endcase
  endfunction

  // Mostly realistic elements: a start point plus a modest offset.
  function automatic fesm_pkg::in_item_t rand_element();
    fesm_pkg::in_item_t el;
    int                 r;
    int                 sh;
    r  = $urandom_range(0, 99);
    sh = $urandom_range(0, 31);
    el.start_x = $urandom;
    el.start_y = $urandom;
    el.end_x   = $urandom;
    el.end_y   = $urandom;
    if (r < 70) begin
      el.start_x = int'($urandom) >>> $urandom_range(0, 12);
      el.start_y = int'($urandom) >>> $urandom_range(0, 12);
      el.end_x   = el.start_x + (int'($urandom) >>> sh);
      el.end_y   = el.start_y + (int'($urandom) >>> sh);
    end else if (r < 80) begin
      el.end_x = el.start_x;
    end else if (r < 88) begin
      el.end_y = el.start_y;
    end else if (r < 93) begin
      el.end_x = el.start_x;
      el.end_y = el.start_y;
    end
    return el;
  endfunction

  // Result side: random stalls, plus an optional long hold-off.
  initial begin
    int gap;
    out_pop = 1'b0;
    gap = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_pop = 1'b0;
        hold_cycles--;
      end else if (gap > 0) begin
        out_pop = 1'b0;
        gap--;
      end else begin
        out_pop = 1'b1;
        gap = eager_pop ? 0 : pick_gap();
      end
    end
  end

  // Compares each popped entry with the oldest expectation.
  always @(posedge clk) begin
    fesm_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (entries_due.size() == 0) begin
        $error("unexpected entry row %0d col %0d value %0d",
               out_data.row_index, out_data.col_index, out_data.entry_value);
        fail_count++;
      end else begin
        want = entries_due.pop_front();
        if (out_data.row_index !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, out_data.row_index);
          fail_count++;
        end
        if (out_data.col_index !== want.col_index) begin
          $error("col_index: expected %0d, got %0d", want.col_index, out_data.col_index);
          fail_count++;
        end
        if (out_data.entry_value !== want.entry_value) begin
          $error("entry_value (%0d,%0d): expected %0d, got %0d", want.row_index,
                 want.col_index, want.entry_value, out_data.entry_value);
          fail_count++;
        end
        if (out_data.last_entry !== want.last_entry) begin
          $error("last_entry: expected %0b, got %0b", want.last_entry, out_data.last_entry);
          fail_count++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, out_data.degenerate);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rigidities are still zero from reset, so every entry must be zero.
  task automatic test_zero_rigidity();
    send_points(0, 0, 32'h0001_0000, 0);
    send_points(-5, 7, 1000, -2000);
    drain();
  endtask

  task automatic test_extremes();
    write_rigidity(fesm_pkg::CFG_AXIAL, RIG_MAX);
    write_rigidity(fesm_pkg::CFG_BENDING, RIG_MAX);
    drain();
    send_points(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_points(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_points(0, 0, 1, 0);
    send_points(0, 0, 0, -1);
    send_points(3, 3, 4, 4);
    send_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
  endtask

  task automatic test_orientations();
    write_rigidity(fesm_pkg::CFG_AXIAL, 48'h0001_0000_0000);
    write_rigidity(fesm_pkg::CFG_BENDING, 48'h0000_0100_0000);
    drain();
    send_points(0, 0, 32'h0005_0000, 0);
    send_points(0, 0, 0, 32'h0005_0000);
    send_points(0, 0, -32'sh0003_0000, 32'h0004_0000);
    send_points(32'h0002_0000, 32'h0002_0000, -32'sh0001_0000, -32'sh0002_0000);
    send_points(32'h1234_5678, -32'sh1234_5678, 32'h1234_5678, -32'sh1234_5678);
    send_points(0, 0, 0, 0);
    drain();
  endtask

  // Writes to unused indices must leave both rigidities alone.
  task automatic test_spare_indices();
    write_rigidity(CFG_SPARE_LOW, RIG_MAX);
    write_rigidity(CFG_SPARE_HIGH, 48'h5555_AAAA_5555);
    drain();
    send_points(0, 0, 32'h0007_0000, 32'h0001_8000);
    drain();
  endtask

  // The receiver holds off long enough for the block to fill and push back.
  task automatic test_backpressure();
    write_rigidity(fesm_pkg::CFG_AXIAL, 48'h0000_0010_0000);
    write_rigidity(fesm_pkg::CFG_BENDING, 48'h0000_0002_0000);
    drain();
    eager_send = 1'b1;
    hold_cycles = 4000;
    repeat (8) send_element(rand_element());
    eager_send = 1'b0;
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      write_rigidity(fesm_pkg::CFG_AXIAL, rand_rigidity());
      write_rigidity(fesm_pkg::CFG_BENDING, rand_rigidity());
      drain();
      eager_send = (ph % 3 == 2);
      eager_pop  = (ph % 4 == 3);
      repeat (per_phase) send_element(rand_element());
      eager_send = 1'b0;
      eager_pop  = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = fesm_pkg::CFG_AXIAL;
    cfg_data    = '0;
    ea_now      = '0;
    ei_now      = '0;
    fail_count  = 0;
    cycle_count = 0;
    hold_cycles = 0;
    eager_send  = 1'b0;
    eager_pop   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_rigidity();
    test_extremes();
    test_orientations();
    test_spare_indices();
    test_backpressure();
    test_random(10, 32);
    write_rigidity(fesm_pkg::CFG_AXIAL, '0);
    write_rigidity(fesm_pkg::CFG_BENDING, '0);
    drain();
    send_points(-32'sh0001_0000, 0, 32'h0001_0000, 0);
    drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
